### hdl/nusp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nusp_pkg
// Types and constants shared by the Annex B NAL unit stream parser.
// ----------------------------------------------------------------------------
package nusp_pkg;

    // one byte of the Annex B stream
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_unit;
    } in_t;

    // one parsed result
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        last;
        logic        forbidden_bit;
        logic [1:0]  ref_priority;
        logic [4:0]  unit_type;
        logic [1:0]  ext_kind;
        logic [22:0] ext_bits;
        logic        idr_picture;
        logic        depth_picture;
        logic [2:0]  header_length;
    } out_t;

    // parser phase, one-hot
    typedef enum logic [3:0] {
        PH_SEARCH  = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_EXT     = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } phase_t;

    // extension kinds
    localparam logic [1:0] EXT_NONE = 2'd0;
    localparam logic [1:0] EXT_SVC  = 2'd1;
    localparam logic [1:0] EXT_MVC  = 2'd2;
    localparam logic [1:0] EXT_3DAVC = 2'd3;

    // NAL unit types of interest
    localparam logic [4:0] NT_IDR      = 5'd5;
    localparam logic [4:0] NT_PREFIX   = 5'd14;
    localparam logic [4:0] NT_SLICE_EXT = 5'd20;
    localparam logic [4:0] NT_DEPTH_EXT = 5'd21;

    // stream byte codes
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] BYTE_EPB  = 8'h03;

    // header lengths
    localparam logic [2:0] HLEN_BASE  = 3'd1;
    localparam logic [2:0] HLEN_3DAVC = 3'd3;
    localparam logic [2:0] HLEN_EXT   = 3'd4;

endpackage

### hdl/nal_unit_stream_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nal_unit_stream_parser
// Annex B byte stream parser: start code search, NAL and extension header
// parsing, emulation prevention removal.
// ----------------------------------------------------------------------------
// The parser takes one stream byte per clock and returns at most one result
// per byte, at a sustained rate of one byte per cycle while no result waits on
// out_ready. A byte passes an input register and then the parse logic into a
// result register, from which its result is presented. The input register
// holds one further byte while a result waits on out_ready. Bytes that give
// no result (start code search, header bytes, dropped 0x03) move on even
// while the result register is full. The end_of_unit flag, not a start code,
// closes a unit; the final result carries last, and a unit that ends on a
// header byte or a dropped 0x03 ends with a marker that has byte_valid low.
module nal_unit_stream_parser
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  nusp_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output nusp_pkg::out_t out_data
);
    import nusp_pkg::*;

    // input stage
    logic        in_valid_reg;
    in_t         in_data_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [1:0]  zero_run_reg, zero_run_next;
    logic [1:0]  header_index_reg, header_index_next;
    logic [7:0]  header_word_reg, header_word_next;
    logic [1:0]  ext_kind_reg, ext_kind_next;
    logic [22:0] ext_shift_reg, ext_shift_next;

    // result stage
    logic        res_valid_reg;
    out_t        res_reg;
    out_t        res_next;

    logic        produce;
    logic        advance;
    logic [7:0]  emit_byte;
    logic        emit_valid;
    logic        emit_last;
    logic [4:0]  cur_type;
    logic [4:0]  new_type;
    logic [1:0]  need;
    logic [7:0]  b;
    logic        eou;

    assign b   = in_data_reg.in_byte;
    assign eou = in_data_reg.end_of_unit;
    assign cur_type = header_word_reg[4:0];

    // parse logic
    always_comb
    begin
        phase_next        = phase_reg;
        zero_run_next     = zero_run_reg;
        header_index_next = header_index_reg;
        header_word_next  = header_word_reg;
        ext_kind_next     = ext_kind_reg;
        ext_shift_next    = ext_shift_reg;
        produce           = 1'b0;
        emit_byte         = BYTE_ZERO;
        emit_valid        = 1'b0;
        emit_last         = 1'b0;
        need              = 2'd3;
        case (phase_reg)
            PH_SEARCH:
            begin
                if (eou)
                begin
                    zero_run_next = 2'd0;
                end
                else if (b == BYTE_ZERO)
                begin
                    if (zero_run_reg < 2'd2)
                    begin
                        zero_run_next = zero_run_reg + 2'd1;
                    end
                end
                else if (b == BYTE_ONE && zero_run_reg >= 2'd2)
                begin
                    phase_next        = PH_HEADER;
                    zero_run_next     = 2'd0;
                    header_index_next = 2'd0;
                    header_word_next  = 8'd0;
                    ext_kind_next     = EXT_NONE;
                    ext_shift_next    = 23'd0;
                end
                else
                begin
                    zero_run_next = 2'd0;
                end
            end
            PH_HEADER:
            begin
                header_word_next  = b;
                header_index_next = 2'd0;
                zero_run_next     = 2'd0;
                if (b[4:0] inside {NT_PREFIX, NT_SLICE_EXT, NT_DEPTH_EXT})
                begin
                    phase_next = PH_EXT;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
                if (eou)
                begin
                    produce    = 1'b1;
                    emit_last  = 1'b1;
                    phase_next = PH_SEARCH;
                end
            end
            PH_EXT:
            begin
                if (header_index_reg == 2'd0)
                begin
                    if (cur_type == NT_DEPTH_EXT)
                    begin
                        ext_kind_next = b[7] ? EXT_3DAVC : EXT_MVC;
                    end
                    else
                    begin
                        ext_kind_next = b[7] ? EXT_SVC : EXT_MVC;
                    end
                    ext_shift_next = {16'd0, b[6:0]};
                end
                else
                begin
                    ext_shift_next = {ext_shift_reg[14:0], b};
                end
                header_index_next = header_index_reg + 2'd1;
                need = (ext_kind_next == EXT_3DAVC) ? 2'd2 : 2'd3;
                if (header_index_next >= need)
                begin
                    phase_next    = PH_PAYLOAD;
                    zero_run_next = 2'd0;
                end
                if (eou)
                begin
                    produce       = 1'b1;
                    emit_last     = 1'b1;
                    phase_next    = PH_SEARCH;
                    zero_run_next = 2'd0;
                end
            end
            default:
            begin
                if (zero_run_reg >= 2'd2 && b == BYTE_EPB)
                begin
                    // emulation prevention byte dropped
                    zero_run_next = 2'd0;
                    if (eou)
                    begin
                        produce    = 1'b1;
                        emit_last  = 1'b1;
                        phase_next = PH_SEARCH;
                    end
                end
                else
                begin
                    if (b == BYTE_ZERO)
                    begin
                        if (zero_run_reg < 2'd2)
                        begin
                            zero_run_next = zero_run_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        zero_run_next = 2'd0;
                    end
                    produce    = 1'b1;
                    emit_byte  = b;
                    emit_valid = 1'b1;
                    emit_last  = eou;
                    if (eou)
                    begin
                        phase_next    = PH_SEARCH;
                        zero_run_next = 2'd0;
                    end
                end
            end
        endcase
    end

    // result fields from the updated header state
    assign new_type = header_word_next[4:0];

    always_comb
    begin
        res_next.payload_byte  = emit_byte;
        res_next.byte_valid    = emit_valid;
        res_next.last          = emit_last;
        res_next.forbidden_bit = header_word_next[7];
        res_next.ref_priority  = header_word_next[6:5];
        res_next.unit_type     = new_type;
        res_next.ext_kind      = ext_kind_next;
        res_next.ext_bits      = ext_shift_next;
        res_next.idr_picture   = (new_type == NT_IDR);
        if (new_type == NT_DEPTH_EXT)
        begin
            res_next.depth_picture = (ext_kind_next == EXT_3DAVC) ? ext_shift_next[6] : 1'b1;
        end
        else
        begin
            res_next.depth_picture = 1'b0;
        end
        if (ext_kind_next == EXT_3DAVC)
        begin
            res_next.header_length = HLEN_3DAVC;
        end
        else if (ext_kind_next != EXT_NONE)
        begin
            res_next.header_length = HLEN_EXT;
        end
        else
        begin
            res_next.header_length = HLEN_BASE;
        end
    end

    // handshake between stages
    assign advance   = in_valid_reg && (!produce || !res_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SEARCH;
            zero_run_reg     <= 2'd0;
            header_index_reg <= 2'd0;
            header_word_reg  <= 8'd0;
            ext_kind_reg     <= EXT_NONE;
            ext_shift_reg    <= 23'd0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            zero_run_reg     <= zero_run_next;
            header_index_reg <= header_index_next;
            header_word_reg  <= header_word_next;
            ext_kind_reg     <= ext_kind_next;
            ext_shift_reg    <= ext_shift_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance && produce)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            res_reg <= res_next;
        end
    end

    // checks
    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_valid |-> out_data.last)
        else $error("end-only marker without last");

    a_zero_run_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        zero_run_reg != 2'd3)
        else $error("zero run count past saturation");

    a_3davc_needs_type21: assert property (@(posedge clk) disable iff (!rst_n)
        ext_kind_reg == EXT_3DAVC |-> header_word_reg[4:0] == NT_DEPTH_EXT)
        else $error("3D-AVC extension on a unit type other than 21");

    a_input_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("stalled request lost from input register");

endmodule
